// File: rtl/rps_pkg.sv
// shared types and constants for the rotated pixel scatter core
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

    // field widths of the stream words
    localparam int PIX_W      = 24;
    localparam int ROW_W      = 13;
    localparam int COLF_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // fixed point position accumulators
    localparam int POS_W = 40;
    localparam int CMP_W = POS_W + 1;

    // source column counter
    localparam int COL_W         = 12;
    localparam int SRC_COL_LIMIT = 4096;

    // register reset values
    localparam logic [16:0] COS_RESET = 17'h10000;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_STEP     = 3'd0,
        CFG_SIN_STEP     = 3'd1,
        CFG_NEG_TAN_STEP = 3'd2,
        CFG_COL_OFFSET   = 3'd3,
        CFG_LINE_COUNT   = 3'd4,
        CFG_SOURCE_COLS  = 3'd5,
        CFG_DEST_ROWS    = 3'd6,
        CFG_DEST_COLS    = 3'd7
    } cfg_idx_t;

    // raw register contents
    typedef struct packed {
        logic [16:0]        cos_step;
        logic [16:0]        sin_step;
        logic signed [22:0] neg_tan_step;
        logic [13:0]        col_offset;
        logic [13:0]        line_count;
        logic [12:0]        source_cols;
        logic [13:0]        dest_rows;
        logic [13:0]        dest_cols;
    } cfg_t;

    // one pixel with its placement and the writes it needs
    typedef struct packed {
        logic             need0;
        logic             need1;
        logic [ROW_W-1:0] row;
        logic [COLF_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/rotated_pixel_scatter_core.sv
// top level of the rotated pixel scatter core
`timescale 1ns / 1ps
`default_nettype none

// Forward-mapping rotation scatter: each source pixel word on s_axis is placed at
// (floor y, floor x + col_offset) and at the row below, and every placement inside
// the destination image leaves as one write word on m_axis (tlast on the final
// write of a pixel); placements out of bounds are dropped. A pixel with two writes
// holds the input until its first write issues; the single output port carries one
// write per cycle unless m_axis stalls. Writes go via pending and output registers.
// Positions are kept in FRAC_BITS fixed point; write registers only when idle.

module rotated_pixel_scatter_core #(
    parameter int MAX_DIM   = 8192,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_wen,
    input  wire logic [rps_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [rps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // source pixels
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // pixel_in
    // destination writes
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [55:0]                            m_axis_tdata,  // dest_row, dest_col, pixel_out
    output logic                                   m_axis_tlast   // last_write
);
    import rps_pkg::*;

    cfg_t              cfg;
    job_t              job;
    logic              accept;
    logic [ROW_W-1:0]  out_row;
    logic [COLF_W-1:0] out_col;
    logic [PIX_W-1:0]  out_pix;

    assign accept = s_axis_tvalid && s_axis_tready;

    // register bank
    rps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // position tracking and placement
    rps_step #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .pixel  (s_axis_tdata),
        .job    (job)
    );

    // write issue
    rps_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .job      (job),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_row    (out_row),
        .m_col    (out_col),
        .m_pixel  (out_pix),
        .m_last   (m_axis_tlast)
    );

    // pack the write word
    assign m_axis_tdata = {6'b0, out_pix, out_col, out_row};

endmodule

`default_nettype wire

// File: rtl/rps_cfg.sv
// configuration register bank of the rotated pixel scatter core
`timescale 1ns / 1ps
`default_nettype none

module rps_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [rps_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [rps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output rps_pkg::cfg_t                         cfg
);
    import rps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_COS_STEP:     cfg_next.cos_step     = cfg_wdata[16:0];
                CFG_SIN_STEP:     cfg_next.sin_step     = cfg_wdata[16:0];
                CFG_NEG_TAN_STEP: cfg_next.neg_tan_step = $signed(cfg_wdata[22:0]);
                CFG_COL_OFFSET:   cfg_next.col_offset   = cfg_wdata[13:0];
                CFG_LINE_COUNT:   cfg_next.line_count   = cfg_wdata[13:0];
                CFG_SOURCE_COLS:  cfg_next.source_cols  = cfg_wdata[12:0];
                CFG_DEST_ROWS:    cfg_next.dest_rows    = cfg_wdata[13:0];
                CFG_DEST_COLS:    cfg_next.dest_cols    = cfg_wdata[13:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_step     <= COS_RESET;
            cfg_reg.sin_step     <= '0;
            cfg_reg.neg_tan_step <= '0;
            cfg_reg.col_offset   <= '0;
            cfg_reg.line_count   <= '0;
            cfg_reg.source_cols  <= 13'd1;
            cfg_reg.dest_rows    <= 14'd1;
            cfg_reg.dest_cols    <= 14'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/rps_step.sv
// line and column counters, position accumulators and write placement
`timescale 1ns / 1ps
`default_nettype none

module rps_step #(
    parameter int MAX_DIM   = 8192,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  rps_pkg::cfg_t                    cfg,
    input  wire logic                        accept,
    input  wire logic [rps_pkg::PIX_W-1:0]   pixel,
    output rps_pkg::job_t                    job
);
    import rps_pkg::*;

    localparam int LINE_W = $clog2(MAX_DIM);
    localparam int LCNT_W = LINE_W + 1;
    localparam int SCOL_W = COL_W + 1;

    logic [LINE_W-1:0]       line_reg, line_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic signed [POS_W-1:0] lxs_reg, lxs_next;
    logic signed [POS_W-1:0] x_reg, x_next;
    logic signed [POS_W-1:0] y_reg, y_next;

    logic [LCNT_W-1:0] lines;
    logic [LCNT_W-1:0] rows_lim;
    logic [LCNT_W-1:0] cols_lim;
    logic [SCOL_W-1:0] src_cols;
    logic              active;
    logic              col_last;
    logic              line_last;

    logic signed [CMP_W-1:0] x_floor;
    logic signed [CMP_W-1:0] y_floor;
    logic signed [CMP_W-1:0] y_floor1;
    logic signed [CMP_W-1:0] dcol;
    logic signed [CMP_W-1:0] rows_lim_s;
    logic signed [CMP_W-1:0] cols_lim_s;
    logic                    col_ok;
    logic                    row0_ok;
    logic                    row1_ok;

    // clamp register values to the supported ranges
    always_comb
    begin
        lines    = (32'(cfg.line_count) > 32'(MAX_DIM)) ? LCNT_W'(MAX_DIM)
                                                         : LCNT_W'(cfg.line_count);
        rows_lim = (32'(cfg.dest_rows) > 32'(MAX_DIM)) ? LCNT_W'(MAX_DIM)
                                                        : LCNT_W'(cfg.dest_rows);
        cols_lim = (32'(cfg.dest_cols) > 32'(MAX_DIM)) ? LCNT_W'(MAX_DIM)
                                                        : LCNT_W'(cfg.dest_cols);
        if (32'(cfg.source_cols) > 32'(SRC_COL_LIMIT))
            src_cols = SCOL_W'(SRC_COL_LIMIT);
        else if (cfg.source_cols == '0)
            src_cols = SCOL_W'(1);
        else
            src_cols = SCOL_W'(cfg.source_cols);
    end

    assign active = (lines != '0);

    // integer position and bounds checks
    always_comb
    begin
        x_floor    = CMP_W'(x_reg >>> FRAC_BITS);
        y_floor    = CMP_W'(y_reg >>> FRAC_BITS);
        y_floor1   = y_floor + CMP_W'(1);
        dcol       = x_floor + CMP_W'($signed({1'b0, cfg.col_offset}));
        rows_lim_s = CMP_W'($signed({1'b0, rows_lim}));
        cols_lim_s = CMP_W'($signed({1'b0, cols_lim}));
        col_ok     = (dcol >= 0) && (dcol < cols_lim_s);
        row0_ok    = (y_floor >= 0) && (y_floor < rows_lim_s);
        row1_ok    = (y_floor1 >= 0) && (y_floor1 < rows_lim_s);
    end

    // placement of this word's writes
    always_comb
    begin
        job.need0 = active && col_ok && row0_ok;
        job.need1 = active && col_ok && row1_ok;
        job.row   = y_floor[ROW_W-1:0];
        job.col   = dcol[COLF_W-1:0];
        job.pixel = pixel;
    end

    // counter and accumulator advance
    always_comb
    begin
        col_last  = (SCOL_W'(col_reg) + SCOL_W'(1)) >= src_cols;
        line_last = (LCNT_W'(line_reg) + LCNT_W'(1)) >= lines;
        line_next = line_reg;
        col_next  = col_reg;
        lxs_next  = lxs_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (accept && active)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (line_last)
                begin
                    line_next = '0;
                    lxs_next  = '0;
                end
                else
                begin
                    line_next = line_reg + LINE_W'(1);
                    lxs_next  = lxs_reg + POS_W'(cfg.neg_tan_step);
                end
                x_next = lxs_next;
                y_next = $signed(POS_W'(line_next)) <<< FRAC_BITS;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                x_next   = x_reg + $signed(POS_W'(cfg.cos_step));
                y_next   = y_reg + $signed(POS_W'(cfg.sin_step));
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            col_reg  <= '0;
            lxs_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
        end
        else
        begin
            line_reg <= line_next;
            col_reg  <= col_next;
            lxs_reg  <= lxs_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rps_emit.sv
// pending write register and output word register
`timescale 1ns / 1ps
`default_nettype none

module rps_emit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  rps_pkg::job_t                      job,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rps_pkg::ROW_W-1:0]          m_row,
    output logic [rps_pkg::COLF_W-1:0]         m_col,
    output logic [rps_pkg::PIX_W-1:0]          m_pixel,
    output logic                               m_last
);
    import rps_pkg::*;

    logic              need0_reg, need0_next;
    logic              need1_reg, need1_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COLF_W-1:0] col_reg, col_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;

    logic              mv_reg, mv_next;
    logic [ROW_W-1:0]  mrow_reg, mrow_next;
    logic [COLF_W-1:0] mcol_reg, mcol_next;
    logic [PIX_W-1:0]  mpix_reg, mpix_next;
    logic              mlast_reg, mlast_next;

    logic pending;
    logic out_load;
    logic accept;

    assign pending  = need0_reg || need1_reg;
    assign out_load = !mv_reg || m_ready;
    assign in_ready = !pending || (out_load && !(need0_reg && need1_reg));
    assign accept   = in_valid && in_ready;

    // issue one write a cycle while the output is not stalled, then take the next pixel
    always_comb
    begin
        need0_next = need0_reg;
        need1_next = need1_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pix_next   = pix_reg;
        mv_next    = mv_reg;
        mrow_next  = mrow_reg;
        mcol_next  = mcol_reg;
        mpix_next  = mpix_reg;
        mlast_next = mlast_reg;
        if (out_load)
        begin
            mv_next = pending;
            if (need0_reg)
            begin
                mrow_next  = row_reg;
                mcol_next  = col_reg;
                mpix_next  = pix_reg;
                mlast_next = !need1_reg;
                need0_next = 1'b0;
            end
            else if (need1_reg)
            begin
                mrow_next  = row_reg + ROW_W'(1);
                mcol_next  = col_reg;
                mpix_next  = pix_reg;
                mlast_next = 1'b1;
                need1_next = 1'b0;
            end
        end
        if (accept)
        begin
            need0_next = job.need0;
            need1_next = job.need1;
            row_next   = job.row;
            col_next   = job.col;
            pix_next   = job.pixel;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need0_reg <= 1'b0;
            need1_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            need0_reg <= need0_next;
            need1_reg <= need1_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        pix_reg   <= pix_next;
        mrow_reg  <= mrow_next;
        mcol_reg  <= mcol_next;
        mpix_reg  <= mpix_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid = mv_reg;
    assign m_row   = mrow_reg;
    assign m_col   = mcol_reg;
    assign m_pixel = mpix_reg;
    assign m_last  = mlast_reg;

    // a new pixel only enters when the held one finishes this cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pending) |-> out_load)
        else $error("pixel taken while earlier writes still pending");

    // a first-of-two word always has its second write queued behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && !mlast_reg) |-> need1_reg)
        else $error("non-final write without a second write pending");

    // two pending writes block the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (need0_reg && need1_reg) |-> !in_ready)
        else $error("input open while two writes pending");

endmodule

`default_nettype wire

// File: verif/scatter_write_checker.sv
// scoreboard for the rotated pixel scatter core: predicts write words per pixel word
`timescale 1ns / 1ps

module scatter_write_checker #(
    parameter int MAX_DIM   = 8192,
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // pixel_in
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [55:0]                    m_axis_tdata,  // dest_row, dest_col, pixel_out
    input  logic                           m_axis_tlast,  // last_write
    output int                             pending,
    output int                             fail_count
);
    import rps_pkg::*;

    localparam int COL_LSB = ROW_W;
    localparam int PIX_LSB = ROW_W + COLF_W;
    localparam int PAD_LSB = ROW_W + COLF_W + PIX_W;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COLF_W-1:0] col;
        logic [PIX_W-1:0]  pixel;
        logic              last;
    } scatter_write_t;

    scatter_write_t expected_writes[$];
    scatter_write_t head_write;
    cfg_t           regs;

    // walk state of the rotation
    logic [12:0]      line_idx;
    logic [COL_W-1:0] col_idx;
    longint           line_x0;
    longint           x_pos;
    longint           y_pos;
    int               mismatches;

    function automatic longint clamp_dim(input longint v, input longint hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // place one pixel, queue the writes it causes, then step the position walk
    task automatic scatter_pixel(input logic [PIX_W-1:0] pix);
        longint         lines;
        longint         src_cols;
        longint         rows_lim;
        longint         cols_lim;
        longint         xf;
        longint         yf;
        longint         c;
        longint         r;
        scatter_write_t wr [2];
        int             n;
        lines    = clamp_dim(longint'(regs.line_count), MAX_DIM);
        src_cols = clamp_dim(longint'(regs.source_cols), SRC_COL_LIMIT);
        rows_lim = clamp_dim(longint'(regs.dest_rows), MAX_DIM);
        cols_lim = clamp_dim(longint'(regs.dest_cols), MAX_DIM);
        n = 0;
        if (src_cols == 0)
            src_cols = 1;
        if (lines == 0)
            return;

        // arithmetic shift floors toward minus infinity
        xf = x_pos >>> FRAC_BITS;
        yf = y_pos >>> FRAC_BITS;
        c  = xf + longint'(regs.col_offset);
        if (c >= 0 && c < cols_lim)
        begin
            for (r = yf; r <= yf + 1; r++)
            begin
                if (r >= 0 && r < rows_lim)
                begin
                    wr[n].row   = ROW_W'(r);
                    wr[n].col   = COLF_W'(c);
                    wr[n].pixel = pix;
                    wr[n].last  = 1'b0;
                    n++;
                end
            end
        end
        if (n > 0)
            wr[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_writes.push_back(wr[k]);

        // end of line restarts the walk, end of frame returns to the origin
        if (longint'(col_idx) + 1 >= src_cols)
        begin
            col_idx = '0;
            if (longint'(line_idx) + 1 >= lines)
            begin
                line_idx = '0;
                line_x0  = 0;
            end
            else
            begin
                line_idx = line_idx + 1'b1;
                line_x0  = line_x0 + longint'(signed'(regs.neg_tan_step));
            end
            x_pos = line_x0;
            y_pos = longint'(line_idx) <<< FRAC_BITS;
        end
        else
        begin
            col_idx = col_idx + 1'b1;
            x_pos   = x_pos + longint'(regs.cos_step);
            y_pos   = y_pos + longint'(regs.sin_step);
        end
    endtask

    // watch register writes, write words and pixel words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.cos_step     = COS_RESET;
            regs.sin_step     = '0;
            regs.neg_tan_step = '0;
            regs.col_offset   = '0;
            regs.line_count   = '0;
            regs.source_cols  = 13'd1;
            regs.dest_rows    = 14'd1;
            regs.dest_cols    = 14'd1;
            line_idx   = '0;
            col_idx    = '0;
            line_x0    = 0;
            x_pos      = 0;
            y_pos      = 0;
            mismatches = 0;
            expected_writes.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_COS_STEP:     regs.cos_step     = cfg_wdata[16:0];
                    CFG_SIN_STEP:     regs.sin_step     = cfg_wdata[16:0];
                    CFG_NEG_TAN_STEP: regs.neg_tan_step = cfg_wdata[22:0];
                    CFG_COL_OFFSET:   regs.col_offset   = cfg_wdata[13:0];
                    CFG_LINE_COUNT:   regs.line_count   = cfg_wdata[13:0];
                    CFG_SOURCE_COLS:  regs.source_cols  = cfg_wdata[12:0];
                    CFG_DEST_ROWS:    regs.dest_rows    = cfg_wdata[13:0];
                    CFG_DEST_COLS:    regs.dest_cols    = cfg_wdata[13:0];
                    default: ;
                endcase
            end

            // compare each write word with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("write word with nothing pending: row %0d col %0d pixel 0x%0h",
                           m_axis_tdata[ROW_W-1:0], m_axis_tdata[COL_LSB +: COLF_W],
                           m_axis_tdata[PIX_LSB +: PIX_W]);
                    mismatches++;
                end
                else
                begin
                    head_write = expected_writes.pop_front();
                    check_field("dest_row", 32'(head_write.row), 32'(m_axis_tdata[ROW_W-1:0]));
                    check_field("dest_col", 32'(head_write.col),
                                32'(m_axis_tdata[COL_LSB +: COLF_W]));
                    check_field("pixel_out", 32'(head_write.pixel),
                                32'(m_axis_tdata[PIX_LSB +: PIX_W]));
                    check_field("last_write", 32'(head_write.last), 32'(m_axis_tlast));
                    check_field("tdata padding", 32'd0, 32'(m_axis_tdata[55:PAD_LSB]));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                scatter_pixel(s_axis_tdata);

            pending    <= expected_writes.size();
            fail_count <= mismatches;
        end
    end

endmodule

// File: verif/testbench.sv
// top of the rotated pixel scatter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    import rps_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIXEL_TARGET = 2000;
    localparam int CALM_TAIL    = 300;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;  // pixel_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [55:0]           m_axis_tdata;        // dest_row, dest_col, pixel_out
    logic                  m_axis_tlast;        // last_write
    int                    pending;
    int                    fail_count;

    bit gaps_on     = 1'b1;
    bit calm        = 1'b0;
    int stall_left  = 0;
    int cycles      = 0;
    int pixels_sent = 0;

    rotated_pixel_scatter_core i_dut (.*);

    scatter_write_checker i_scatter_check (.*);

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // write word sink with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (gaps_on && !calm && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic int pick(input int a, input int b);
        return ($urandom_range(0, 1) != 0) ? a : b;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int cos_v, input int sin_v,
                                input int ntan_v, input int off_v,
                                input int lines_v, input int scols_v,
                                input int drows_v, input int dcols_v);
        write_reg(CFG_COS_STEP, CFG_DATA_W'(cos_v));
        write_reg(CFG_SIN_STEP, CFG_DATA_W'(sin_v));
        write_reg(CFG_NEG_TAN_STEP, CFG_DATA_W'(ntan_v));
        write_reg(CFG_COL_OFFSET, CFG_DATA_W'(off_v));
        write_reg(CFG_LINE_COUNT, CFG_DATA_W'(lines_v));
        write_reg(CFG_SOURCE_COLS, CFG_DATA_W'(scols_v));
        write_reg(CFG_DEST_ROWS, CFG_DATA_W'(drows_v));
        write_reg(CFG_DEST_COLS, CFG_DATA_W'(dcols_v));
        cfg_wen <= 1'b0;
    endtask

    // one pixel word, optionally after an idle burst
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (gaps_on && !calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    // let every predicted write leave, then allow the pipeline to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_phase();
        int kind;
        int lines;
        int scols;
        int off;
        int n_pix;
        int k;
        kind = $urandom_range(0, 9);
        gaps_on <= ($urandom_range(0, 3) != 0);
        if (kind < 7)
        begin
            // well-formed frames that mostly land on the canvas
            lines = $urandom_range(1, 12);
            scols = $urandom_range(1, 24);
            off   = $urandom_range(0, 16);
            set_geometry($urandom_range(0, 65536), $urandom_range(0, 65536),
                         -int'($urandom_range(0, 98304)), off, lines, scols,
                         $urandom_range(lines, lines + scols + 2),
                         $urandom_range(scols / 2 + 1, scols + off + 2));
            n_pix = lines * scols * $urandom_range(1, 3);
        end
        else if (kind < 9)
        begin
            // register extremes, including clamped and zero sizes
            set_geometry(pick(0, 65536), pick(0, 65536), pick(-4194304, 0), pick(0, 8192),
                         pick(1, 16383), pick(0, 8191), pick(0, 16383), pick(1, 8192));
            n_pix = $urandom_range(30, 80);
        end
        else
        begin
            // raw noise on every register bit
            set_geometry($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            n_pix = $urandom_range(20, 60);
        end
        for (k = 0; k < n_pix; k++)
            send_pixel(($urandom_range(0, 15) == 0) ? PIX_W'(pick(0, 24'hFFFFFF))
                                                     : PIX_W'($urandom));
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings have zero line count: pixels are swallowed
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        drain();

        // two lines of three on a 2x3 canvas, row below drops off on the second line
        set_geometry(65536, 0, 0, 0, 2, 3, 2, 3);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        send_pixel(24'hAAAAAA);
        send_pixel(24'h555555);
        send_pixel(24'h0F0F0F);
        send_pixel(24'hF0F0F0);
        drain();

        // extremes with clamped sizes, column offset pushes writes past the right edge
        set_geometry(0, 65536, -4194304, 8192, 16383, 8191, 16383, 8192);
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);
        send_pixel(24'h800001);
        drain();

        // zero-height canvas, zero source columns acting as one
        set_geometry(40000, 30000, -49152, 0, 4, 0, 0, 8);
        send_pixel(24'h7F7F7F);
        send_pixel(24'h808080);
        drain();

        // zero-width canvas
        set_geometry(40000, 30000, -49152, 0, 4, 0, 8, 0);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);
        drain();

        // negative start column on later lines drops their writes
        set_geometry(40000, 30000, -49152, 0, 4, 0, 8, 8);
        send_pixel(24'h111111);
        send_pixel(24'h222222);
        send_pixel(24'h333333);
        send_pixel(24'h444444);
        drain();

        // random phases, no idling in the tail
        while (pixels_sent < PIXEL_TARGET)
        begin
            if (pixels_sent >= PIXEL_TARGET - CALM_TAIL)
                calm <= 1'b1;
            random_phase();
        end

        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
